FILE: design/differential_drive_odometry_assert.svh
// Assertion macros for the odometry block.
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_ASSERT_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_ASSERT_SVH
`ifndef SYNTHESIS
// Condition that must hold at every clock edge outside reset.
`define DDO_ASSERT_HOLDS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Condition that must hold in the cycle after the trigger.
`define DDO_ASSERT_NEXT(lbl, clk, rst_n, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) else $error(msg);
`else
`define DDO_ASSERT_HOLDS(lbl, clk, rst_n, cond, msg)
`define DDO_ASSERT_NEXT(lbl, clk, rst_n, trig, cond, msg)
`endif
`endif

FILE: design/ddo_pkg.sv
package ddo_pkg;

    localparam int CORDIC_STEPS = 20;

    localparam int WORD_W  = 32;
    localparam int HEAD_W  = 25;
    localparam int CFG_IDX_W = 2;

    // CORDIC datapath widths: vector magnitude stays below 2^39, angle below 2^32
    localparam int CORDIC_W   = 42;
    localparam int ANGLE_W    = 34;
    localparam int ATAN_IDX_W = 5;

    // Half-turn folding: 180 deg in Q.24 is 45 * 2^26, so the remainder by 45
    // is taken over the product bits above 26, two bits per step
    localparam int MOD_DIVISOR = 45;
    localparam int MOD_A_W     = 38;
    localparam int MOD_STEPS   = MOD_A_W / 2;

    localparam int ITER_N = (CORDIC_STEPS > MOD_STEPS) ? CORDIC_STEPS : MOD_STEPS;
    localparam int CNT_W  = $clog2(ITER_N + 1);

    localparam logic signed [HEAD_W-1:0] HALF_TURN_Q16    = 25'sd11796480;
    localparam logic signed [HEAD_W-1:0] QUARTER_TURN_Q16 = 25'sd5898240;
    localparam logic [WORD_W-1:0]        GAIN_INV_Q32     = 32'd2608131496;

    localparam logic [CFG_IDX_W-1:0] REG_DISTANCE_GAIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEADING_GAIN  = 2'd1;

    typedef logic signed [WORD_W-1:0] t_count;
    typedef logic signed [WORD_W-1:0] t_pos;
    typedef logic signed [HEAD_W-1:0] t_heading;
    typedef logic [WORD_W-1:0]        t_word;
    typedef logic [CFG_IDX_W-1:0]     t_cfg_idx;

    // arctan(2^-i) in degrees, Q.24
    function automatic logic [29:0] atan_deg_q24(input logic [ATAN_IDX_W-1:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0:  v = 30'd754974720;
            5'd1:  v = 30'd445687602;
            5'd2:  v = 30'd235489088;
            5'd3:  v = 30'd119537938;
            5'd4:  v = 30'd60000934;
            5'd5:  v = 30'd30029717;
            5'd6:  v = 30'd15018523;
            5'd7:  v = 30'd7509720;
            5'd8:  v = 30'd3754917;
            5'd9:  v = 30'd1877466;
            5'd10: v = 30'd938734;
            5'd11: v = 30'd469367;
            5'd12: v = 30'd234684;
            5'd13: v = 30'd117342;
            5'd14: v = 30'd58671;
            5'd15: v = 30'd29335;
            5'd16: v = 30'd14668;
            5'd17: v = 30'd7334;
            5'd18: v = 30'd3667;
            5'd19: v = 30'd1833;
            5'd20: v = 30'd917;
            5'd21: v = 30'd458;
            5'd22: v = 30'd229;
            5'd23: v = 30'd115;
            5'd24: v = 30'd57;
            5'd25: v = 30'd29;
            5'd26: v = 30'd14;
            5'd27: v = 30'd7;
            5'd28: v = 30'd4;
            5'd29: v = 30'd2;
            5'd30: v = 30'd1;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

FILE: design/ddo_ifs.sv
interface ddo_tick_if;
    import ddo_pkg::*;
    logic   valid;
    logic   ready;
    t_count left_count;
    t_count right_count;
    modport source(output valid, output left_count, output right_count, input ready);
    modport sink(input valid, input left_count, input right_count, output ready);
endinterface

interface ddo_pose_if;
    import ddo_pkg::*;
    logic     valid;
    logic     ready;
    t_pos     pos_x;
    t_pos     pos_y;
    t_heading heading;
    modport source(output valid, output pos_x, output pos_y, output heading, input ready);
    modport sink(input valid, input pos_x, input pos_y, input heading, output ready);
endinterface

interface ddo_cfg_if;
    import ddo_pkg::*;
    logic     valid;
    logic     ready;
    t_cfg_idx index;
    t_word    data;
    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface

FILE: design/differential_drive_odometry.sv
// Ticks are taken only in idle; a new tick waits until the pose of the last one leaves
// the CORDIC loop and is written to the output slot, which waits while the output
// is not drained. The shared rotation and remainder step and the shared 32x32
// multiplier keep the block to one tick at a time.
// Reset (i_rst_n low, synchronous): gains, last counts, pose and heading go to zero,
// the sequencer returns to idle and the output slot empties.
`include "differential_drive_odometry_assert.svh"
module differential_drive_odometry (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ddo_cfg_if.sink    i_cfg,
    ddo_tick_if.sink   i_tick,
    ddo_pose_if.source o_pose
);
    import ddo_pkg::*;

    // Sequencer: one item at a time. The multiplier is shared by the heading
    // product, the distance product and the CORDIC gain compensation; the
    // rotation step and the mod-45 step then run side by side in the rotate state.
    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_DELTA = 8'b0000_0010,
        S_MUL_H = 8'b0000_0100,
        S_MUL_D = 8'b0000_1000,
        S_MUL_G = 8'b0001_0000,
        S_INIT  = 8'b0010_0000,
        S_ROT   = 8'b0100_0000,
        S_FIN   = 8'b1000_0000
    } t_state;

    t_state r_state;

    // Configuration and architectural state
    t_word    r_dist_gain;
    t_word    r_head_gain;
    t_word    r_last_left;
    t_word    r_last_right;
    t_pos     r_x_acc;
    t_pos     r_y_acc;
    t_heading r_heading;
    logic     r_out_valid;

    // Working registers for the item in flight
    logic [WORD_W-1:0]          r_dl;
    logic [WORD_W-1:0]          r_dr;
    logic [WORD_W:0]            r_diff;
    logic [WORD_W:0]            r_sum_mag;
    logic                       r_sum_neg;
    logic [WORD_W-1:0]          r_diff_mag;
    logic                       r_diff_pos;
    logic [2*WORD_W-1:0]        r_prod;
    logic signed [CORDIC_W-1:0] r_x;
    logic signed [CORDIC_W-1:0] r_y;
    logic signed [ANGLE_W-1:0]  r_z;
    logic [CNT_W-1:0]           r_cnt;
    logic [MOD_A_W-1:0]         r_mod_a;
    logic [5:0]                 r_mod_r;
    logic                       r_k_lsb;
    logic [17:0]                r_hm_lo;

    // One remainder step by 45: shift two dividend bits in, subtract up to 3x
    function automatic logic [5:0] mod45_step(input logic [5:0] rem, input logic [1:0] dig);
        logic [7:0] t;
        logic [5:0] res;
        t = {rem, dig};
        if (t >= 8'(3 * MOD_DIVISOR)) begin
            res = 6'(t - 8'(3 * MOD_DIVISOR));
        end else if (t >= 8'(2 * MOD_DIVISOR)) begin
            res = 6'(t - 8'(2 * MOD_DIVISOR));
        end else if (t >= 8'(MOD_DIVISOR)) begin
            res = 6'(t - 8'(MOD_DIVISOR));
        end else begin
            res = 6'(t);
        end
        return res;
    endfunction

    // ---------------------------------------------------------------
    // Shared multiplier: operands picked by the sequencer state
    // ---------------------------------------------------------------
    logic [WORD_W-1:0]   w_mul_a;
    logic [WORD_W-1:0]   w_mul_b;
    logic [2*WORD_W-1:0] w_mul_p;
    logic [30:0]         w_dist_m;

    // Distance in Q16.16, saturated to 0x7FFFFFFF
    assign w_dist_m = (r_prod[2*WORD_W-1:39] != '0) ? 31'h7FFF_FFFF : r_prod[38:8];

    always_comb begin
        case (r_state)
            S_MUL_H: begin
                w_mul_a = r_diff_mag;
                w_mul_b = r_head_gain;
            end
            S_MUL_D: begin
                w_mul_a = r_sum_mag[WORD_W-1:0];
                w_mul_b = r_dist_gain;
            end
            S_MUL_G: begin
                w_mul_a = {1'b0, w_dist_m};
                w_mul_b = GAIN_INV_Q32;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_mul_p = w_mul_a * w_mul_b;

    // ---------------------------------------------------------------
    // Delta stage: sum of wheel deltas and right-minus-left, both magnitudes
    // ---------------------------------------------------------------
    logic [WORD_W:0] w_sum;
    assign w_sum = {r_dl[WORD_W-1], r_dl} + {r_dr[WORD_W-1], r_dr};

    // ---------------------------------------------------------------
    // CORDIC start: fold the previous heading into +-90 deg, flip the vector
    // ---------------------------------------------------------------
    logic signed [HEAD_W:0]     w_theta;
    logic signed [HEAD_W:0]     w_theta_adj;
    logic                       w_flip;
    logic signed [ANGLE_W-1:0]  w_z0;
    logic [CORDIC_W-1:0]        w_x0_mag;

    assign w_theta = {r_heading[HEAD_W-1], r_heading};

    always_comb begin
        if (w_theta > (HEAD_W + 1)'(QUARTER_TURN_Q16)) begin
            w_theta_adj = w_theta - (HEAD_W + 1)'(HALF_TURN_Q16);
            w_flip      = 1'b1;
        end else if (w_theta < -(HEAD_W + 1)'(QUARTER_TURN_Q16)) begin
            w_theta_adj = w_theta + (HEAD_W + 1)'(HALF_TURN_Q16);
            w_flip      = 1'b1;
        end else begin
            w_theta_adj = w_theta;
            w_flip      = 1'b0;
        end
    end

    assign w_z0     = ANGLE_W'(w_theta_adj) <<< 8;
    assign w_x0_mag = CORDIC_W'(r_prod[62:24]);

    // ---------------------------------------------------------------
    // Shared rotation step: one shift pair and one add/sub per axis
    // ---------------------------------------------------------------
    logic [ATAN_IDX_W-1:0]      w_idx;
    logic signed [CORDIC_W-1:0] w_xs;
    logic signed [CORDIC_W-1:0] w_ys;
    logic signed [ANGLE_W-1:0]  w_atan;
    logic                       w_rot_on;
    logic                       w_mod_on;

    assign w_idx    = r_cnt[ATAN_IDX_W-1:0];
    assign w_xs     = r_x >>> w_idx;
    assign w_ys     = r_y >>> w_idx;
    assign w_atan   = signed'(ANGLE_W'(atan_deg_q24(w_idx)));
    assign w_rot_on = (r_cnt < CNT_W'(CORDIC_STEPS));
    assign w_mod_on = (r_cnt < CNT_W'(MOD_STEPS));

    // ---------------------------------------------------------------
    // Heading fold: k odd comes from the dividend LSB and the remainder LSB
    // (45 is odd); du is the remainder in Q.16 degrees, always below 180
    // ---------------------------------------------------------------
    logic [23:0]            w_du;
    logic signed [HEAD_W-1:0] w_du_s;
    logic                   w_k_odd;
    t_heading               w_head;

    assign w_du    = {r_mod_r, r_hm_lo};
    assign w_du_s  = signed'(HEAD_W'(w_du));
    assign w_k_odd = r_k_lsb ^ r_mod_r[0];

    always_comb begin
        case ({w_k_odd, r_diff_pos})
            2'b11:   w_head = w_du_s - HALF_TURN_Q16;
            2'b10:   w_head = HALF_TURN_Q16 - w_du_s;
            2'b01:   w_head = w_du_s;
            default: w_head = -w_du_s;
        endcase
    end

    logic w_fin_go;
    assign w_fin_go = (r_state == S_FIN) && (!r_out_valid || o_pose.ready);

    // ---------------------------------------------------------------
    // Control and architectural state
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_dist_gain  <= '0;
            r_head_gain  <= '0;
            r_last_left  <= '0;
            r_last_right <= '0;
            r_x_acc      <= '0;
            r_y_acc      <= '0;
            r_heading    <= '0;
            r_out_valid  <= 1'b0;
            r_cnt        <= '0;
        end else begin
            // Configuration writes land at once; writes to unknown indexes drop
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    REG_DISTANCE_GAIN: r_dist_gain <= i_cfg.data;
                    REG_HEADING_GAIN:  r_head_gain <= i_cfg.data;
                    default: ;
                endcase
            end

            // Refill the output slot with a finished pose, else free it when
            // the pose transaction completes
            if (w_fin_go) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_pose.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_tick.valid) begin
                        r_last_left  <= i_tick.left_count;
                        r_last_right <= i_tick.right_count;
                        r_state      <= S_DELTA;
                    end
                end
                S_DELTA: r_state <= S_MUL_H;
                S_MUL_H: r_state <= S_MUL_D;
                S_MUL_D: r_state <= S_MUL_G;
                S_MUL_G: r_state <= S_INIT;
                S_INIT: begin
                    r_cnt   <= '0;
                    r_state <= S_ROT;
                end
                S_ROT: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(ITER_N - 1)) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    // Hold the finished pose until the output slot is free
                    if (w_fin_go) begin
                        r_x_acc     <= r_x_acc + r_x[WORD_W+7:8];
                        r_y_acc     <= r_y_acc + r_y[WORD_W+7:8];
                        r_heading   <= w_head;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Datapath registers (no reset)
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                // Wheel deltas wrap to 32 bits; right-minus-left is exact
                r_dl   <= i_tick.left_count - r_last_left;
                r_dr   <= i_tick.right_count - r_last_right;
                r_diff <= {i_tick.right_count[WORD_W-1], i_tick.right_count}
                        - {i_tick.left_count[WORD_W-1], i_tick.left_count};
            end
            S_DELTA: begin
                r_sum_neg  <= w_sum[WORD_W];
                r_sum_mag  <= w_sum[WORD_W] ? (~w_sum + 1'b1) : w_sum;
                r_diff_mag <= r_diff[WORD_W] ? WORD_W'(~r_diff + 1'b1) : r_diff[WORD_W-1:0];
                r_diff_pos <= !r_diff[WORD_W] && (r_diff != '0);
            end
            S_MUL_H: begin
                r_prod <= w_mul_p;
            end
            S_MUL_D: begin
                // Split the heading product for the remainder unit
                r_mod_a <= r_prod[2*WORD_W-1:26];
                r_mod_r <= '0;
                r_k_lsb <= r_prod[26];
                r_hm_lo <= r_prod[25:8];
                // A summed magnitude of exactly 2^32 has zero low bits
                r_prod  <= r_sum_mag[WORD_W] ? {r_dist_gain, {WORD_W{1'b0}}} : w_mul_p;
            end
            S_MUL_G: begin
                r_prod <= w_mul_p;
            end
            S_INIT: begin
                r_x <= (r_sum_neg ^ w_flip) ? -signed'(w_x0_mag) : signed'(w_x0_mag);
                r_y <= '0;
                r_z <= w_z0;
            end
            S_ROT: begin
                if (w_rot_on) begin
                    if (!r_z[ANGLE_W-1]) begin
                        r_x <= r_x - w_ys;
                        r_y <= r_y + w_xs;
                        r_z <= r_z - w_atan;
                    end else begin
                        r_x <= r_x + w_ys;
                        r_y <= r_y - w_xs;
                        r_z <= r_z + w_atan;
                    end
                end
                if (w_mod_on) begin
                    r_mod_r <= mod45_step(r_mod_r, r_mod_a[MOD_A_W-1 -: 2]);
                    r_mod_a <= r_mod_a << 2;
                end
            end
            default: ;
        endcase
    end

    // ---------------------------------------------------------------
    // Ports
    // ---------------------------------------------------------------
    assign i_cfg.ready    = 1'b1;
    assign i_tick.ready   = (r_state == S_IDLE);
    assign o_pose.valid   = r_out_valid;
    assign o_pose.pos_x   = r_x_acc;
    assign o_pose.pos_y   = r_y_acc;
    assign o_pose.heading = r_heading;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `DDO_ASSERT_NEXT(a_pose_held, i_clk, i_rst_n, r_out_valid && !o_pose.ready, $stable(r_x_acc) && $stable(r_y_acc) && $stable(r_heading), "pose changed while the result waits")
    `DDO_ASSERT_HOLDS(a_heading_range, i_clk, i_rst_n, (r_heading >= -HALF_TURN_Q16) && (r_heading <= HALF_TURN_Q16), "heading outside half turn")
    `DDO_ASSERT_HOLDS(a_mod_rem, i_clk, i_rst_n, (r_state != S_ROT && r_state != S_FIN) || (r_mod_r < 6'(MOD_DIVISOR)), "remainder by 45 out of range")

endmodule
